[src/alu8_pkg.sv]
`default_nettype none

package alu8_pkg;

   // operation codes
   localparam logic [4:0] ACT_ADD  = 5'd0;
   localparam logic [4:0] ACT_ADC  = 5'd1;
   localparam logic [4:0] ACT_SUB  = 5'd2;
   localparam logic [4:0] ACT_SBC  = 5'd3;
   localparam logic [4:0] ACT_AND  = 5'd4;
   localparam logic [4:0] ACT_OR   = 5'd5;
   localparam logic [4:0] ACT_XOR  = 5'd6;
   localparam logic [4:0] ACT_CP   = 5'd7;
   localparam logic [4:0] ACT_INC  = 5'd8;
   localparam logic [4:0] ACT_DEC  = 5'd9;
   localparam logic [4:0] ACT_SWAP = 5'd10;
   localparam logic [4:0] ACT_DAA  = 5'd11;
   localparam logic [4:0] ACT_CPL  = 5'd12;
   localparam logic [4:0] ACT_CCF  = 5'd13;
   localparam logic [4:0] ACT_SCF  = 5'd14;
   localparam logic [4:0] ACT_RLC  = 5'd15;
   localparam logic [4:0] ACT_RL   = 5'd16;
   localparam logic [4:0] ACT_RRC  = 5'd17;
   localparam logic [4:0] ACT_RR   = 5'd18;
   localparam logic [4:0] ACT_SLA  = 5'd19;
   localparam logic [4:0] ACT_SRA  = 5'd20;
   localparam logic [4:0] ACT_SRL  = 5'd21;
   localparam logic [4:0] ACT_BIT  = 5'd22;
   localparam logic [4:0] ACT_SET  = 5'd23;
   localparam logic [4:0] ACT_RES  = 5'd24;
   localparam logic [4:0] ACT_RLA  = 5'd25;

   // flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // decimal adjust constants
   localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
   localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
   localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

   typedef struct packed {
      logic [4:0] action;
      logic [7:0] accumulator;
      logic [7:0] operand;
      logic [2:0] bit_index;
      logic [3:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags_out;
      logic       writes_result;
   } rsp_type;

endpackage

`default_nettype wire

[src/cpu_alu_8bit_with_flags.sv]
`default_nettype none

// eight-bit alu with zero, subtract, half-carry and carry flags
//
// request channel: req_valid / req_ready / req_payload carries the operation,
// accumulator, operand, bit index and incoming flags
// response channel: rsp_valid / rsp_ready / rsp_payload carries the 8-bit
// result, the new flags and the write-back strobe
//
// a request is captured in the input register, the alu logic works on it,
// and the answer lands in the output register
// throughput is one request per cycle while the receiver does not stall;
// the alu logic is a single pass between those two registers
//
// reset (synchronous, active high) empties both registers; no request is
// held and rsp_valid is low
// when the receiver stalls, the output register holds its response and the
// input register holds the next one; req_ready drops only when both are full
module cpu_alu_8bit_with_flags (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire alu8_pkg::req_type req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      alu8_pkg::rsp_type rsp_payload
);
   import alu8_pkg::*;

   req_type    in_ff;
   req_type    in_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   rsp_type    out_ff;
   rsp_type    out_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_take;

   rsp_type    alu_rsp;
   logic       cin;
   logic       tin;
   logic [8:0] sum9;
   logic [4:0] hsum5;
   logic [8:0] diff9;
   logic [4:0] hdiff5;
   logic [7:0] daa_mid;
   logic [7:0] daa_val;
   logic       daa_hi;
   logic       daa_lo;
   logic       daa_c;
   logic [7:0] rot_src;
   logic [7:0] bit_mask;
   logic [7:0] r;

   // handshake: the output register frees whenever the receiver takes it
   assign out_take  = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || out_take;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   // shared arithmetic on the captured request
   assign cin    = in_ff.flags_in[FLAG_C];
   assign tin    = (in_ff.action == ACT_ADC || in_ff.action == ACT_SBC) ? cin : 1'b0;
   assign sum9   = {1'b0, in_ff.accumulator} + {1'b0, in_ff.operand} + {8'd0, tin};
   assign hsum5  = {1'b0, in_ff.accumulator[3:0]} + {1'b0, in_ff.operand[3:0]}
                 + {4'd0, tin};
   assign diff9  = {1'b0, in_ff.accumulator} - {1'b0, in_ff.operand} - {8'd0, tin};
   assign hdiff5 = {1'b0, in_ff.accumulator[3:0]} - {1'b0, in_ff.operand[3:0]}
                 - {4'd0, tin};

   // decimal adjust
   always_comb begin
      daa_hi  = cin || (in_ff.accumulator > DAA_HI_LIMIT);
      daa_lo  = in_ff.flags_in[FLAG_H] || (in_ff.accumulator[3:0] > DAA_LO_LIMIT);
      daa_mid = '0;
      daa_val = '0;
      daa_c   = cin;
      if (!in_ff.flags_in[FLAG_N]) begin
         daa_mid = in_ff.accumulator + (daa_hi ? DAA_HI_ADJ : 8'd0);
         daa_val = daa_mid + (daa_lo ? DAA_LO_ADJ : 8'd0);
         daa_c   = daa_hi;
      end else begin
         daa_mid = in_ff.accumulator - (cin ? DAA_HI_ADJ : 8'd0);
         daa_val = daa_mid - (in_ff.flags_in[FLAG_H] ? DAA_LO_ADJ : 8'd0);
      end
   end

   assign rot_src  = (in_ff.action == ACT_RLA) ? in_ff.accumulator : in_ff.operand;
   assign bit_mask = 8'd1 << in_ff.bit_index;

   // operation select
   always_comb begin
      r = in_ff.accumulator;
      alu_rsp.result        = in_ff.accumulator;
      alu_rsp.flags_out     = in_ff.flags_in;
      alu_rsp.writes_result = 1'b1;
      case (in_ff.action)
         ACT_ADD, ACT_ADC: begin
            r = sum9[7:0];
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 1'b0, hsum5[4], sum9[8]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            r = diff9[7:0];
            alu_rsp.flags_out = {r == 8'd0, 1'b1, hdiff5[4], diff9[8]};
            if (in_ff.action == ACT_CP) begin
               alu_rsp.writes_result = 1'b0;
            end else begin
               alu_rsp.result = r;
            end
         end
         ACT_AND: begin
            r = in_ff.accumulator & in_ff.operand;
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         ACT_OR: begin
            r = in_ff.accumulator | in_ff.operand;
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 3'b000};
         end
         ACT_XOR: begin
            r = in_ff.accumulator ^ in_ff.operand;
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 3'b000};
         end
         ACT_INC: begin
            r = in_ff.operand + 8'd1;
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 1'b0, in_ff.operand[3:0] == 4'hF, cin};
         end
         ACT_DEC: begin
            r = in_ff.operand - 8'd1;
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 1'b1, in_ff.operand[3:0] == 4'h0, cin};
         end
         ACT_SWAP: begin
            r = {in_ff.operand[3:0], in_ff.operand[7:4]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 3'b000};
         end
         ACT_DAA: begin
            alu_rsp.result    = daa_val;
            alu_rsp.flags_out = {daa_val == 8'd0, in_ff.flags_in[FLAG_N], 1'b0, daa_c};
         end
         ACT_CPL: begin
            alu_rsp.result    = ~in_ff.accumulator;
            alu_rsp.flags_out = {in_ff.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
         end
         ACT_CCF: begin
            alu_rsp.flags_out     = {in_ff.flags_in[FLAG_Z], 1'b0, 1'b0, !cin};
            alu_rsp.writes_result = 1'b0;
         end
         ACT_SCF: begin
            alu_rsp.flags_out     = {in_ff.flags_in[FLAG_Z], 1'b0, 1'b0, 1'b1};
            alu_rsp.writes_result = 1'b0;
         end
         ACT_RLC: begin
            r = {in_ff.operand[6:0], in_ff.operand[7]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[7]};
         end
         ACT_RL: begin
            r = {rot_src[6:0], cin};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, rot_src[7]};
         end
         ACT_RLA: begin
            r = {rot_src[6:0], cin};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {3'b000, rot_src[7]};
         end
         ACT_RRC: begin
            r = {in_ff.operand[0], in_ff.operand[7:1]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[0]};
         end
         ACT_RR: begin
            r = {cin, in_ff.operand[7:1]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[0]};
         end
         ACT_SLA: begin
            r = {in_ff.operand[6:0], 1'b0};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[7]};
         end
         ACT_SRA: begin
            r = {in_ff.operand[7], in_ff.operand[7:1]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[0]};
         end
         ACT_SRL: begin
            r = {1'b0, in_ff.operand[7:1]};
            alu_rsp.result    = r;
            alu_rsp.flags_out = {r == 8'd0, 2'b00, in_ff.operand[0]};
         end
         ACT_BIT: begin
            alu_rsp.flags_out     = {!in_ff.operand[in_ff.bit_index], 1'b0, 1'b1, cin};
            alu_rsp.writes_result = 1'b0;
         end
         ACT_SET: begin
            alu_rsp.result = in_ff.operand | bit_mask;
         end
         ACT_RES: begin
            alu_rsp.result = in_ff.operand & ~bit_mask;
         end
         default: begin
            // unknown operation: no-op, nothing written back
            alu_rsp.writes_result = 1'b0;
         end
      endcase
   end

   // register next values
   always_comb begin
      in_in        = in_ff;
      in_valid_in  = in_valid_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_take) begin
         out_in       = alu_rsp;
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_in       = req_payload;
         in_valid_in = 1'b1;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

[src/alu8_checker.sv]
`default_nettype none

module alu8_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire alu8_pkg::req_type req_payload,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire alu8_pkg::rsp_type rsp_payload
);
   import alu8_pkg::*;

   // a stalled request holds its value
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("stalled request changed or dropped");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed or dropped");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the output empty the pipeline can always take a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a draining output frees room for a request in the same cycle
   a_ready_when_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

endmodule

bind cpu_alu_8bit_with_flags alu8_checker u_alu8_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[verif/tb_cpu_alu_8bit_with_flags.sv]
module tb_cpu_alu_8bit_with_flags;
   import alu8_pkg::*;

   // action codes the block treats as no-ops
   localparam logic [4:0] ACT_NOP_FIRST = 5'd26;
   localparam logic [4:0] ACT_NOP_LAST  = 5'd31;

   localparam int unsigned HANG_LIMIT = 2000;
   localparam int unsigned OPS_PER_PHASE = 230;

   // sender idle and receiver stall, percent, per phase
   localparam int unsigned PHASE_IDLE  [4] = '{0, 65, 0, 24};
   localparam int unsigned PHASE_STALL [4] = '{0, 0, 65, 24};

   localparam logic [7:0] CORNER_BYTES [10] =
      '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'hF0, 8'hFF};
   localparam logic [4:0] BCD_ACTIONS [4] = '{ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC};

   typedef struct {
      req_type     op;
      int unsigned idle_pct;
      int unsigned stall_pct;
      bit          wait_empty;
   } alu_op_slot_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   alu_op_slot_type pending_ops[$];
   rsp_type     expected_results[$];
   int unsigned total_ops = 0;
   int unsigned ops_accepted = 0;
   int unsigned results_accepted = 0;
   int unsigned quiet_cycles = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned errors = 0;

   cpu_alu_8bit_with_flags dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // expected alu outcome; flags are packed {zero, subtract, half, carry}
   function automatic rsp_type compute_alu_result(req_type op);
      rsp_type    res;
      logic [8:0] full;
      logic [4:0] half;
      logic [7:0] a;
      logic [7:0] n;
      logic       cin;
      logic       cy;
      a = op.accumulator;
      n = op.operand;
      cin = op.flags_in[FLAG_C];
      cy = (op.action == ACT_ADC || op.action == ACT_SBC) ? cin : 1'b0;
      res.result = a;
      res.flags_out = op.flags_in;
      res.writes_result = 1'b1;
      case (op.action)
         ACT_ADD, ACT_ADC: begin
            full = {1'b0, a} + {1'b0, n} + {8'b0, cy};
            half = {1'b0, a[3:0]} + {1'b0, n[3:0]} + {4'b0, cy};
            res.result = full[7:0];
            res.flags_out = {full[7:0] == 8'h00, 1'b0, half[4], full[8]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            // borrow shows up as the sign bit of the widened difference
            full = {1'b0, a} - {1'b0, n} - {8'b0, cy};
            half = {1'b0, a[3:0]} - {1'b0, n[3:0]} - {4'b0, cy};
            res.result = full[7:0];
            res.flags_out = {full[7:0] == 8'h00, 1'b1, half[4], full[8]};
            if (op.action == ACT_CP) begin
               res.result = a;
               res.writes_result = 1'b0;
            end
         end
         ACT_AND: begin
            res.result = a & n;
            res.flags_out = {res.result == 8'h00, 1'b0, 1'b1, 1'b0};
         end
         ACT_OR: begin
            res.result = a | n;
            res.flags_out = {res.result == 8'h00, 3'b000};
         end
         ACT_XOR: begin
            res.result = a ^ n;
            res.flags_out = {res.result == 8'h00, 3'b000};
         end
         ACT_INC: begin
            res.result = n + 8'd1;
            res.flags_out = {res.result == 8'h00, 1'b0, n[3:0] == 4'hF, cin};
         end
         ACT_DEC: begin
            res.result = n - 8'd1;
            res.flags_out = {res.result == 8'h00, 1'b1, n[3:0] == 4'h0, cin};
         end
         ACT_SWAP: begin
            res.result = {n[3:0], n[7:4]};
            res.flags_out = {res.result == 8'h00, 3'b000};
         end
         ACT_DAA: begin
            full = {1'b0, a};
            cy = cin;
            if (!op.flags_in[FLAG_N]) begin
               if (cy || a > DAA_HI_LIMIT) begin
                  full = full + {1'b0, DAA_HI_ADJ};
                  cy = 1'b1;
               end
               if (op.flags_in[FLAG_H] || full[3:0] > DAA_LO_LIMIT) begin
                  full = full + {1'b0, DAA_LO_ADJ};
               end
            end else begin
               if (cy) begin
                  full = full - {1'b0, DAA_HI_ADJ};
               end
               if (op.flags_in[FLAG_H]) begin
                  full = full - {1'b0, DAA_LO_ADJ};
               end
            end
            res.result = full[7:0];
            res.flags_out = {full[7:0] == 8'h00, op.flags_in[FLAG_N], 1'b0, cy};
         end
         ACT_CPL: begin
            res.result = ~a;
            res.flags_out = {op.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
         end
         ACT_CCF: begin
            res.flags_out = {op.flags_in[FLAG_Z], 1'b0, 1'b0, ~cin};
            res.writes_result = 1'b0;
         end
         ACT_SCF: begin
            res.flags_out = {op.flags_in[FLAG_Z], 1'b0, 1'b0, 1'b1};
            res.writes_result = 1'b0;
         end
         ACT_RLC: begin
            res.result = {n[6:0], n[7]};
            res.flags_out = {res.result == 8'h00, 2'b00, n[7]};
         end
         ACT_RL: begin
            res.result = {n[6:0], cin};
            res.flags_out = {res.result == 8'h00, 2'b00, n[7]};
         end
         ACT_RLA: begin
            // rotate the accumulator, zero always cleared
            res.result = {a[6:0], cin};
            res.flags_out = {3'b000, a[7]};
         end
         ACT_RRC: begin
            res.result = {n[0], n[7:1]};
            res.flags_out = {res.result == 8'h00, 2'b00, n[0]};
         end
         ACT_RR: begin
            res.result = {cin, n[7:1]};
            res.flags_out = {res.result == 8'h00, 2'b00, n[0]};
         end
         ACT_SLA: begin
            res.result = {n[6:0], 1'b0};
            res.flags_out = {res.result == 8'h00, 2'b00, n[7]};
         end
         ACT_SRA: begin
            res.result = {n[7], n[7:1]};
            res.flags_out = {res.result == 8'h00, 2'b00, n[0]};
         end
         ACT_SRL: begin
            res.result = {1'b0, n[7:1]};
            res.flags_out = {res.result == 8'h00, 2'b00, n[0]};
         end
         ACT_BIT: begin
            res.flags_out = {~n[op.bit_index], 1'b0, 1'b1, cin};
            res.writes_result = 1'b0;
         end
         ACT_SET: begin
            res.result = n | (8'h01 << op.bit_index);
         end
         ACT_RES: begin
            res.result = n & ~(8'h01 << op.bit_index);
         end
         default: begin
            res.writes_result = 1'b0;
         end
      endcase
      return res;
   endfunction

   function automatic req_type make_op(logic [4:0] act, logic [7:0] a, logic [7:0] n,
                                       logic [2:0] b, logic [3:0] f);
      req_type op;
      op.action = act;
      op.accumulator = a;
      op.operand = n;
      op.bit_index = b;
      op.flags_in = f;
      return op;
   endfunction

   function automatic logic [7:0] corner_byte();
      logic [7:0] v;
      if ($urandom_range(3) == 0) begin
         v = CORNER_BYTES[$urandom_range(9)];
      end else begin
         v = 8'($urandom_range(255));
      end
      return v;
   endfunction

   function automatic logic [7:0] bcd_byte();
      logic [3:0] hi;
      logic [3:0] lo;
      hi = 4'($urandom_range(9));
      lo = 4'($urandom_range(9));
      return {hi, lo};
   endfunction

   function automatic req_type random_op();
      req_type op;
      req_type prior;
      rsp_type prior_res;
      if ($urandom_range(99) < 4) begin
         op.action = 5'($urandom_range(ACT_NOP_LAST, ACT_NOP_FIRST));
      end else begin
         op.action = 5'($urandom_range(ACT_RLA));
      end
      op.accumulator = corner_byte();
      op.operand = corner_byte();
      op.bit_index = 3'($urandom_range(7));
      op.flags_in = 4'($urandom_range(15));
      // half of the daa ops adjust the outcome of a real bcd add or subtract
      if (op.action == ACT_DAA && $urandom_range(1) == 1) begin
         prior = make_op(BCD_ACTIONS[$urandom_range(3)], bcd_byte(), bcd_byte(), 3'd0,
                         op.flags_in);
         prior_res = compute_alu_result(prior);
         op.accumulator = prior_res.result;
         op.flags_in = prior_res.flags_out;
      end
      return op;
   endfunction

   task automatic queue_op(req_type op, int unsigned idle_pct, int unsigned stall_pct,
                           bit wait_empty);
      alu_op_slot_type slot;
      slot.op = op;
      slot.idle_pct = idle_pct;
      slot.stall_pct = stall_pct;
      slot.wait_empty = wait_empty;
      pending_ops.push_back(slot);
   endtask

   // request driver
   always @(posedge clock) begin : drive_ops
      alu_op_slot_type slot;
      logic       nxt_valid;
      req_type    nxt_op;
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         nxt_valid = req_valid;
         nxt_op = req_payload;
         if (!req_valid || req_ready) begin
            nxt_valid = 1'b0;
            if (pending_ops.size() != 0) begin
               slot = pending_ops[0];
               // optional hold-off until the block has drained
               if (!(slot.wait_empty && (req_valid || ops_accepted != results_accepted))
                   && $urandom_range(99) >= slot.idle_pct) begin
                  void'(pending_ops.pop_front());
                  nxt_valid = 1'b1;
                  nxt_op = slot.op;
                  rsp_stall_pct <= slot.stall_pct;
               end
            end
         end
         req_valid <= nxt_valid;
         req_payload <= nxt_op;
      end
   end

   // response receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin : watch_ports
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(compute_alu_result(req_payload));
            ops_accepted <= ops_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            results_accepted <= results_accepted + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (got.result !== want.result) begin
                  $display("%0t: result expected %02h, got %02h",
                           $time, want.result, got.result);
                  errors++;
               end
               if (got.flags_out !== want.flags_out) begin
                  $display("%0t: flags_out expected %04b, got %04b",
                           $time, want.flags_out, got.flags_out);
                  errors++;
               end
               if (got.writes_result !== want.writes_result) begin
                  $display("%0t: writes_result expected %0b, got %0b",
                           $time, want.writes_result, got.writes_result);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // watchdog
   initial begin
      while (quiet_cycles < HANG_LIMIT) @(posedge clock);
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // stimulus and end of run
   initial begin
      // directed: every operation, field extremes and flag corner cases
      queue_op(make_op(ACT_ADD,  8'hFF, 8'h01, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_ADC,  8'h0F, 8'h00, 3'd0, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_SUB,  8'h00, 8'h01, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_SBC,  8'h10, 8'h0F, 3'd0, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_AND,  8'h0F, 8'hF0, 3'd0, 4'b1111), 0, 0, 1'b0);
      queue_op(make_op(ACT_OR,   8'h00, 8'h00, 3'd0, 4'b1111), 0, 0, 1'b0);
      queue_op(make_op(ACT_XOR,  8'hFF, 8'hFF, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_CP,   8'h80, 8'h80, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_INC,  8'h00, 8'hFF, 3'd0, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_DEC,  8'hFF, 8'h00, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_SWAP, 8'h00, 8'hF0, 3'd0, 4'b1111), 0, 0, 1'b0);
      queue_op(make_op(ACT_DAA,  8'h9A, 8'h00, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_DAA,  8'h00, 8'h00, 3'd0, 4'b0111), 0, 0, 1'b0);
      queue_op(make_op(ACT_CPL,  8'h55, 8'h00, 3'd0, 4'b1001), 0, 0, 1'b0);
      queue_op(make_op(ACT_CCF,  8'hFF, 8'hFF, 3'd7, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_SCF,  8'h00, 8'h00, 3'd0, 4'b1000), 0, 0, 1'b0);
      queue_op(make_op(ACT_RLC,  8'h00, 8'h80, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_RL,   8'h00, 8'h80, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_RRC,  8'h00, 8'h01, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_RR,   8'h00, 8'h01, 3'd0, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_SLA,  8'h00, 8'h80, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_SRA,  8'h00, 8'h81, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_SRL,  8'h00, 8'h01, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_BIT,  8'h00, 8'h7F, 3'd7, 4'b0001), 0, 0, 1'b0);
      queue_op(make_op(ACT_SET,  8'h00, 8'h00, 3'd7, 4'b1010), 0, 0, 1'b0);
      queue_op(make_op(ACT_RES,  8'h00, 8'hFF, 3'd0, 4'b0101), 0, 0, 1'b0);
      queue_op(make_op(ACT_RLA,  8'h80, 8'h00, 3'd0, 4'b0000), 0, 0, 1'b0);
      queue_op(make_op(ACT_NOP_FIRST, 8'hA5, 8'h5A, 3'd3, 4'b1111), 0, 0, 1'b0);
      queue_op(make_op(ACT_NOP_LAST,  8'h3C, 8'hC3, 3'd5, 4'b0110), 0, 0, 1'b0);

      // random phases with different idle and stall mixes
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < OPS_PER_PHASE; i++) begin
            queue_op(random_op(), PHASE_IDLE[p], PHASE_STALL[p], p != 0 && i == 0);
         end
      end
      total_ops = pending_ops.size();

      while (ops_accepted != total_ops || results_accepted != total_ops) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
